### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and rst_n in the calling scope.
`define GRMT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GRMT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/grmt_pkg.sv
package grmt_pkg;

    localparam int POS_W     = 32;
    localparam int FRAC_W    = 14;
    localparam int MAG_W     = POS_W - FRAC_W - 1;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_MARKED = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_MARCH  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic clear;
        logic write;
        logic start;
        logic step;
        logic flush;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic done;
    } status_t;

endpackage

### hdl/grmt_req_if.sv
interface grmt_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic        [5:0]  tile_col;
    logic        [5:0]  tile_row;
    logic        [1:0]  tile_kind;
    logic        [19:0] start_x;
    logic        [19:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;

    modport source (
        output valid, op, tile_col, tile_row, tile_kind, start_x, start_y, dir_x, dir_y,
        input  ready
    );

    modport sink (
        input  valid, op, tile_col, tile_row, tile_kind, start_x, start_y, dir_x, dir_y,
        output ready
    );
endinterface

### hdl/grmt_rsp_if.sv
interface grmt_rsp_if;
    logic valid;
    logic ready;
    logic crosses_marked;

    modport source (
        output valid, crosses_marked,
        input  ready
    );

    modport sink (
        input  valid, crosses_marked,
        output ready
    );
endinterface

### hdl/grmt_ctrl.sv
module grmt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  grmt_pkg::status_t status,
    output grmt_pkg::cmd_t    cmd
);

    grmt_pkg::state_t state_reg;
    grmt_pkg::state_t state_next;
    logic             out_vld_reg;
    logic             out_vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= grmt_pkg::ST_CLEAR;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        if (out_vld_reg && rsp_ready)
        begin
            out_vld_next = 1'b0;
        end
        case (state_reg)
            grmt_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = grmt_pkg::ST_IDLE;
                end
            end
            grmt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_op == grmt_pkg::OP_CAST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = grmt_pkg::ST_MARCH;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            grmt_pkg::ST_MARCH:
            begin
                cmd.step = 1'b1;
                if (status.done)
                begin
                    cmd.flush  = 1'b1;
                    state_next = grmt_pkg::ST_FINISH;
                end
            end
            grmt_pkg::ST_FINISH:
            begin
                // wait for a free output slot
                if (!out_vld_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = grmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = grmt_pkg::ST_CLEAR;
            end
        endcase
    end

    assign rsp_valid = out_vld_reg;

endmodule

### hdl/grmt_datapath.sv
module grmt_datapath #(
    parameter int TILE_PIXELS = 64,
    parameter int MAP_DIM     = 64,
    parameter int MARCH_STEPS = 160,
    parameter int STEP_PIXELS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  grmt_pkg::cmd_t                    cmd,
    output grmt_pkg::status_t                 status,
    input  logic                              cfg_wr_en,
    input  logic [grmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [grmt_pkg::DIM_W-1:0]        cfg_data,
    input  logic [5:0]                        tile_col,
    input  logic [5:0]                        tile_row,
    input  logic [1:0]                        tile_kind,
    input  logic [19:0]                       start_x,
    input  logic [19:0]                       start_y,
    input  logic signed [15:0]                dir_x,
    input  logic signed [15:0]                dir_y,
    output logic                              crosses_marked
);

    localparam int POS_W   = grmt_pkg::POS_W;
    localparam int FRAC_W  = grmt_pkg::FRAC_W;
    localparam int MAG_W   = grmt_pkg::MAG_W;
    localparam int CB      = $clog2(MAP_DIM);
    localparam int ADDR_W  = 2 * CB;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int CNT_W   = $clog2(MARCH_STEPS + 1);
    localparam int TL      = $clog2(TILE_PIXELS);
    localparam int K       = MAG_W + TL;
    localparam int RECIP   = ((1 << K) + TILE_PIXELS - 1) / TILE_PIXELS;
    localparam int R_W     = MAG_W + 2;
    localparam int PROD_W  = MAG_W + R_W;
    localparam int CMP_W   = 9;

    localparam logic [R_W-1:0]          RECIP_C   = R_W'(RECIP);
    localparam logic signed [POS_W-1:0] STEP_S    = POS_W'(STEP_PIXELS);
    localparam logic [MAG_W-1:0]        MAP_DIM_M = MAG_W'(MAP_DIM);
    localparam logic [CMP_W-1:0]        MAP_DIM_C = CMP_W'(MAP_DIM);
    localparam logic [CNT_W-1:0]        CNT_END   = CNT_W'(MARCH_STEPS);
    localparam logic [CNT_W-1:0]        CNT_LAST  = CNT_W'(MARCH_STEPS - 1);

    logic [1:0]                 mem [DEPTH];
    logic [ADDR_W-1:0]          clr_cnt_reg;
    logic [grmt_pkg::DIM_W-1:0] width_reg;
    logic [grmt_pkg::DIM_W-1:0] height_reg;

    logic signed [POS_W-1:0]    pos_x_reg;
    logic signed [POS_W-1:0]    pos_y_reg;
    logic signed [POS_W-1:0]    step_x_reg;
    logic signed [POS_W-1:0]    step_y_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       v4_reg;
    logic                       last1_reg;
    logic                       last2_reg;
    logic                       last3_reg;
    logic                       last4_reg;

    logic [MAG_W-1:0]           mag_x_reg;
    logic [MAG_W-1:0]           mag_y_reg;
    logic                       neg_x2_reg;
    logic                       neg_y2_reg;
    logic [MAG_W-1:0]           q_x_reg;
    logic [MAG_W-1:0]           q_y_reg;
    logic                       neg_x3_reg;
    logic                       neg_y3_reg;
    logic [1:0]                 kind_reg;
    logic                       inr4_reg;
    logic                       res_reg;
    logic                       out_reg;

    logic                       issue;
    logic                       wr_ok;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [POS_W-1:0]    dx_ext;
    logic signed [POS_W-1:0]    dy_ext;
    logic signed [POS_W-1:0]    ax_in;
    logic signed [POS_W-1:0]    ay_in;
    logic [POS_W-1:0]           abs_x;
    logic [POS_W-1:0]           abs_y;
    logic [PROD_W-1:0]          prod_x;
    logic [PROD_W-1:0]          prod_y;
    logic [MAG_W-1:0]           w_eff;
    logic [MAG_W-1:0]           h_eff;
    logic                       inr_x;
    logic                       inr_y;
    logic                       hit;
    logic                       done;

    assign wr_ok   = (CMP_W'(tile_col) < MAP_DIM_C) && (CMP_W'(tile_row) < MAP_DIM_C);
    assign wr_addr = {CB'(tile_row), CB'(tile_col)};
    assign rd_addr = {CB'(q_y_reg), CB'(q_x_reg)};

    assign dx_ext = POS_W'(dir_x);
    assign dy_ext = POS_W'(dir_y);
    assign ax_in  = dx_ext * STEP_S;
    assign ay_in  = dy_ext * STEP_S;

    assign issue  = cmd.step && !cmd.flush && (cnt_reg != CNT_END);

    assign abs_x  = pos_x_reg[POS_W-1] ? (~pos_x_reg + 1'b1) : pos_x_reg;
    assign abs_y  = pos_y_reg[POS_W-1] ? (~pos_y_reg + 1'b1) : pos_y_reg;

    assign prod_x = {{R_W{1'b0}}, mag_x_reg} * {{MAG_W{1'b0}}, RECIP_C};
    assign prod_y = {{R_W{1'b0}}, mag_y_reg} * {{MAG_W{1'b0}}, RECIP_C};

    assign w_eff  = (MAG_W'(width_reg) > MAP_DIM_M) ? MAP_DIM_M : MAG_W'(width_reg);
    assign h_eff  = (MAG_W'(height_reg) > MAP_DIM_M) ? MAP_DIM_M : MAG_W'(height_reg);
    assign inr_x  = (!neg_x3_reg || (q_x_reg == '0)) && (q_x_reg < w_eff);
    assign inr_y  = (!neg_y3_reg || (q_y_reg == '0)) && (q_y_reg < h_eff);

    assign hit    = v4_reg && inr4_reg && (kind_reg == grmt_pkg::KIND_MARKED);
    assign done   = v4_reg && (last4_reg || (inr4_reg &&
                    ((kind_reg == grmt_pkg::KIND_MARKED) || (kind_reg == grmt_pkg::KIND_WALL))));

    assign status.clear_done = (clr_cnt_reg == '1);
    assign status.done       = done;
    assign crosses_marked    = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= grmt_pkg::KIND_EMPTY;
        end
        else if (cmd.write && wr_ok)
        begin
            mem[wr_addr] <= tile_kind;
        end
        kind_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            width_reg   <= grmt_pkg::DIM_RESET;
            height_reg  <= grmt_pkg::DIM_RESET;
            cnt_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    grmt_pkg::CFG_MAP_WIDTH:  width_reg  <= cfg_data;
                    grmt_pkg::CFG_MAP_HEIGHT: height_reg <= cfg_data;
                    default:                  ;
                endcase
            end
            if (cmd.start)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && !cmd.flush;
            v3_reg <= v2_reg && !cmd.flush;
            v4_reg <= v3_reg && !cmd.flush;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pos_x_reg  <= POS_W'({start_x, 6'b0});
            pos_y_reg  <= POS_W'({start_y, 6'b0});
            step_x_reg <= ax_in;
            step_y_reg <= ay_in;
        end
        else if (issue)
        begin
            pos_x_reg <= pos_x_reg + step_x_reg;
            pos_y_reg <= pos_y_reg + step_y_reg;
        end
        last1_reg  <= (cnt_reg == CNT_LAST);
        last2_reg  <= last1_reg;
        last3_reg  <= last2_reg;
        last4_reg  <= last3_reg;
        mag_x_reg  <= abs_x[FRAC_W+MAG_W-1:FRAC_W];
        mag_y_reg  <= abs_y[FRAC_W+MAG_W-1:FRAC_W];
        neg_x2_reg <= pos_x_reg[POS_W-1];
        neg_y2_reg <= pos_y_reg[POS_W-1];
        q_x_reg    <= MAG_W'(prod_x[PROD_W-1:K]);
        q_y_reg    <= MAG_W'(prod_y[PROD_W-1:K]);
        neg_x3_reg <= neg_x2_reg;
        neg_y3_reg <= neg_y2_reg;
        inr4_reg   <= inr_x && inr_y;
        if (done)
        begin
            res_reg <= hit;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

### hdl/grid_ray_march_tile_detect.sv
// Fixed-step ray march over a tile map. After reset the tile memory is swept to empty, one
// entry per cycle, over all 2**(2*clog2(MAP_DIM)) entries (4096 at MAP_DIM = 64); req.ready
// stays low during the sweep while configuration writes are taken. A tile write item is
// stored on acceptance and the block stays ready. A cast item marches until a marked or wall
// tile ends the march or MARCH_STEPS steps have been issued; the result then goes to the
// output register and rsp.valid rises. One march step enters a four-stage pipeline each
// cycle (position add, magnitude, reciprocal multiply for the tile index, tile memory read);
// the single read port of the tile memory sets that step rate. Only one cast is in flight; a
// result waits in the output register while the next item is accepted.
module grid_ray_march_tile_detect #(
    parameter int TILE_PIXELS = 64,
    parameter int MAP_DIM     = 64,
    parameter int MARCH_STEPS = 160,
    parameter int STEP_PIXELS = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    grmt_req_if.sink                       req,
    grmt_rsp_if.source                     rsp,
    input  logic                           cfg_wr_en,
    input  logic [grmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grmt_pkg::DIM_W-1:0]     cfg_data
);

    grmt_pkg::cmd_t    cmd;
    grmt_pkg::status_t status;

    grmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    grmt_datapath #(
        .TILE_PIXELS (TILE_PIXELS),
        .MAP_DIM     (MAP_DIM),
        .MARCH_STEPS (MARCH_STEPS),
        .STEP_PIXELS (STEP_PIXELS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tile_col       (req.tile_col),
        .tile_row       (req.tile_row),
        .tile_kind      (req.tile_kind),
        .start_x        (req.start_x),
        .start_y        (req.start_y),
        .dir_x          (req.dir_x),
        .dir_y          (req.dir_y),
        .crosses_marked (rsp.crosses_marked)
    );

endmodule

### hdl/grmt_checker.sv
`include "assert_macros.svh"

module grmt_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_op,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic crosses_marked
);

    `GRMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(crosses_marked), "stalled result changed")
    `GRMT_ASSERT_NEXT(a_accept_no_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid, "result right after accept")
    `GRMT_ASSERT_NEXT(a_cast_busy, req_valid && req_ready && req_op == grmt_pkg::OP_CAST, !req_ready, "ready during march")
    `GRMT_ASSERT_IMPL(a_rsp_from_march, $rose(rsp_valid), !$past(req_ready), "result while idle")

endmodule

bind grid_ray_march_tile_detect grmt_checker u_grmt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_op         (req.op),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .crosses_marked (rsp.crosses_marked)
);
